// ===== sv/ckrt_pkg.sv =====
// Shared types and constants for the compacting keyed record table.
`default_nettype none
package ckrt_pkg;

	localparam int ENTRIES      = 64;
	localparam int VALUE_BITS   = 64;
	localparam int KEY_W        = 32;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// one write port and one read port, shared by the key and value stores
	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [KEY_W-1:0]      wkey;
		logic [VALUE_BITS-1:0] wval;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

	typedef struct packed {
		logic                  load;
		status_t               status;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      count;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/ckrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ckrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/ckrt_ctrl.sv =====
// Sequencer: append, linear key search with one shared comparator, and compaction.
`default_nettype none
module ckrt_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        operation,
	input  wire logic [ckrt_pkg::KEY_W-1:0]        key,
	input  wire logic [ckrt_pkg::VALUE_BITS-1:0]   value,
	input  wire logic [ckrt_pkg::KEY_W-1:0]        key_rdata,
	input  wire logic [ckrt_pkg::VALUE_BITS-1:0]   val_rdata,
	output ckrt_pkg::mem_req_t                     mem,
	input  wire logic                              out_free,
	output ckrt_pkg::result_t                      res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                              state_q;
	ckrt_pkg::op_t                       op_q;
	logic [ckrt_pkg::KEY_W-1:0]          key_q;
	logic [ckrt_pkg::VALUE_BITS-1:0]     val_q;
	logic [ckrt_pkg::CNT_W-1:0]          count_q;
	logic [ckrt_pkg::CNT_W-1:0]          idx_q;
	logic                                rd_vld_s1;
	logic [ckrt_pkg::IDX_W-1:0]          rd_idx_s1;
	ckrt_pkg::status_t                   res_status_q;
	logic [ckrt_pkg::VALUE_BITS-1:0]     res_value_q;

	logic has_room;
	logic more;
	logic hit;

	assign has_room = count_q < ckrt_pkg::CNT_W'(ckrt_pkg::ENTRIES);
	assign more     = idx_q < count_q;
	// the one key comparator, fed by the registered read of the key store
	assign hit      = (state_q == S_SCAN) && rd_vld_s1 && (key_rdata == key_q);
	assign in_ready = (state_q == S_IDLE);

	assign res.load   = (state_q == S_RESP) && out_free;
	assign res.status = res_status_q;
	assign res.value  = res_value_q;
	assign res.count  = count_q;

	always_comb begin
		mem       = '0;
		mem.raddr = idx_q[ckrt_pkg::IDX_W-1:0];
		case (state_q)
			S_ADD: begin
				mem.we    = has_room;
				mem.waddr = count_q[ckrt_pkg::IDX_W-1:0];
				mem.wkey  = key_q;
				mem.wval  = val_q;
			end
			S_SCAN: begin
				mem.we    = hit && (op_q == ckrt_pkg::OP_UPDATE);
				mem.waddr = rd_idx_s1;
				mem.wkey  = key_rdata;
				mem.wval  = val_q;
			end
			S_SHIFT: begin
				// entry read last cycle moves down one slot
				mem.we    = rd_vld_s1;
				mem.waddr = rd_idx_s1 - 1'b1;
				mem.wkey  = key_rdata;
				mem.wval  = val_rdata;
			end
			default: begin
				mem.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= ckrt_pkg::op_t'(operation);
						key_q       <= key;
						val_q       <= value;
						idx_q       <= '0;
						rd_vld_s1   <= 1'b0;
						res_value_q <= '0;
						if (ckrt_pkg::op_t'(operation) == ckrt_pkg::OP_ADD) begin
							state_q <= S_ADD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_ADD: begin
					if (has_room) begin
						count_q      <= count_q + 1'b1;
						res_status_q <= ckrt_pkg::ST_DONE;
					end else begin
						res_status_q <= ckrt_pkg::ST_FULL;
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					rd_vld_s1 <= more && !hit;
					rd_idx_s1 <= idx_q[ckrt_pkg::IDX_W-1:0];
					if (more && !hit) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						res_status_q <= ckrt_pkg::ST_DONE;
						case (op_q)
							ckrt_pkg::OP_DELETE: begin
								idx_q   <= ckrt_pkg::CNT_W'(rd_idx_s1) + 1'b1;
								state_q <= S_SHIFT;
							end
							ckrt_pkg::OP_LOOKUP: begin
								res_value_q <= val_rdata;
								state_q     <= S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end else if (!rd_vld_s1 && !more) begin
						res_status_q <= ckrt_pkg::ST_MISSING;
						state_q      <= S_RESP;
					end
				end
				S_SHIFT: begin
					rd_vld_s1 <= more;
					rd_idx_s1 <= idx_q[ckrt_pkg::IDX_W-1:0];
					if (more) begin
						idx_q <= idx_q + 1'b1;
					end
					if (!rd_vld_s1 && !more) begin
						count_q      <= count_q - 1'b1;
						res_status_q <= ckrt_pkg::ST_DONE;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/compacting_keyed_record_table.sv =====
// Top level of the compacting keyed record table: stores, sequencer, result register.
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+---------------------------------------
//  in      | in_valid  | in_ready  | operation, key, value_in
//  out     | out_valid | out_ready | status, value_out, entries_used
//
// One word at a time. Add: an add step, then the response step loads the
// result register. Update / lookup: a linear search of the n occupied
// entries (one key read per cycle through the key store's read port, one
// comparator); delete continues from the match with a compaction pass of
// one entry move per cycle, so the search and the moves cover the table once.
// Reset clears the entry count and control state; stores need no clearing pass.
// A waiting result holds in the output register; the sequencer stalls in its
// response step until the register is free, and in_ready stays low meanwhile.
`default_nettype none
module compacting_keyed_record_table (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic signed [31:0] key,
	input  wire logic [63:0]        value_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [63:0]             value_out,
	output logic [6:0]              entries_used
);

	ckrt_pkg::mem_req_t                 mem;
	ckrt_pkg::result_t                  res;
	logic [ckrt_pkg::KEY_W-1:0]         key_rdata;
	logic [ckrt_pkg::VALUE_BITS-1:0]    val_rdata;
	logic                               out_free;

	logic                               out_valid_q;
	ckrt_pkg::status_t                  status_q;
	logic [ckrt_pkg::VALUE_BITS-1:0]    value_q;
	logic [ckrt_pkg::CNT_W-1:0]         used_q;

	// key and value stores move together: same addresses, same write strobe
	ckrt_ram #(
		.WIDTH(ckrt_pkg::KEY_W),
		.DEPTH(ckrt_pkg::ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wkey),
		.raddr(mem.raddr),
		.rdata(key_rdata)
	);

	ckrt_ram #(
		.WIDTH(ckrt_pkg::VALUE_BITS),
		.DEPTH(ckrt_pkg::ENTRIES)
	) u_val_ram (
		.clk  (clk),
		.we   (mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wval),
		.raddr(mem.raddr),
		.rdata(val_rdata)
	);

	ckrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.key      (ckrt_pkg::KEY_W'(key)),
		.value    (value_in[ckrt_pkg::VALUE_BITS-1:0]),
		.key_rdata(key_rdata),
		.val_rdata(val_rdata),
		.mem      (mem),
		.out_free (out_free),
		.res      (res)
	);

	// result register: free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q <= res.status;
			value_q  <= res.value;
			used_q   <= res.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign value_out    = 64'(value_q);
	assign entries_used = 7'(used_q);

endmodule
`default_nettype wire

// ===== sv/ckrt_checker.sv =====
// Port-level assertions for the compacting keyed record table, bound to the top.
`default_nettype none
module ckrt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [1:0]         status,
	input wire logic [63:0]        value_out,
	input wire logic [6:0]         entries_used
);

	// one word in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high the cycle after an accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(value_out) && $stable(entries_used))
		else $error("stalled result changed or dropped");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ckrt_pkg::ST_FULL)
			|-> entries_used == 7'(ckrt_pkg::ENTRIES))
		else $error("table full reported with free entries");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ckrt_pkg::ST_DONE) |-> value_out == 64'd0)
		else $error("nonzero value on failed operation");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_used <= 7'(ckrt_pkg::ENTRIES))
		else $error("entry count beyond table size");

endmodule

bind compacting_keyed_record_table ckrt_checker u_ckrt_checker (.*);
`default_nettype wire
